// ===== rtl/bat_pkg.sv =====
// Shared definitions for the breakpoint address table.
// Field widths, request and status codes, controller states and the cell control bundle.
package bat_pkg;

  // Field widths of the request and result items
  localparam int ADDR_W   = 64;
  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 5;

  // Default number of table slots
  localparam int DEFAULT_TABLE_DEPTH = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEL_AT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_ADDR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  // Control bundle broadcast to every cell
  typedef struct packed {
    logic capture;   // latch the match bit against the incoming address
    logic add_en;    // append the held address at slot count
    logic shift_en;  // close the gap left by a removal
    logic by_index;  // removal point comes from the slot index, not a match
  } cell_ctrl_t;

endpackage

// ===== rtl/breakpoint_address_table.sv =====
// Top level of the breakpoint address table: request controller, row of bat_cell slots,
// and result register. Uses bat_pkg and bat_cell.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | in_valid / in_ready  | req_type, bp_address, slot_index
//   out     | output    | out_valid / out_ready| status, added_slot, live_count
//
// Every cell compares its address in the cycle an item is taken; the append or shift
// across the row happens in the apply state, which also loads the result register. The
// next item is taken only after the apply state commits and the controller returns to idle.
// Reset (rst, synchronous) clears the count and the handshake state; slot contents are
// not cleared and are never read before being written.
// A held result stalls only the apply cycle of the following item.
module breakpoint_address_table #(
  parameter int TABLE_DEPTH = bat_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bat_pkg::REQ_W-1:0]     req_type,
  input  logic [bat_pkg::ADDR_W-1:0]    bp_address,
  input  logic [bat_pkg::SLOT_W-1:0]    slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bat_pkg::STATUS_W-1:0]  status,
  output logic [bat_pkg::SLOT_W-1:0]    added_slot,
  output logic [bat_pkg::LIVE_W-1:0]    live_count
);

  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  bat_pkg::state_t                 state;
  bat_pkg::state_t                 state_next;
  bat_pkg::cell_ctrl_t             ctrl;

  logic [COUNT_W-1:0]              count;
  logic [COUNT_W-1:0]              count_next;
  logic [bat_pkg::REQ_W-1:0]       req_q;
  logic [bat_pkg::ADDR_W-1:0]      addr_q;
  logic [bat_pkg::SLOT_W-1:0]      slot_q;

  logic [bat_pkg::ADDR_W-1:0]      cell_addr;
  logic [bat_pkg::ADDR_W-1:0]      entry [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]            chain;
  logic                            any_hit;

  logic                            commit;
  logic                            add_ok;
  logic                            del_ok;
  logic [bat_pkg::STATUS_W-1:0]    status_next;
  logic [bat_pkg::SLOT_W-1:0]      slot_next;

  // Row of slots; the match prefix ripples left to right
  assign chain[0] = 1'b0;
  assign any_hit  = chain[TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic [bat_pkg::ADDR_W-1:0] right;
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign right = entry[k];
    end else begin : g_mid
      assign right = entry[k+1];
    end

    bat_cell #(
      .IDX     (k),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .pos        (slot_q),
      .addr       (cell_addr),
      .next_entry (right),
      .chain_in   (chain[k]),
      .entry      (entry[k]),
      .chain_out  (chain[k+1])
    );
  end

  // Compare against the port on the accept cycle, write the held address afterwards
  assign cell_addr = (state == bat_pkg::S_IDLE) ? bp_address : addr_q;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bat_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bat_pkg::S_APPLY;
        end
      end
      bat_pkg::S_APPLY: begin
        if (!out_valid || out_ready) begin
          state_next = bat_pkg::S_IDLE;
        end
      end
      default: state_next = bat_pkg::S_IDLE;
    endcase
  end

  // Controller outputs; take nothing while reset is held
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state)
      bat_pkg::S_IDLE:  in_ready = !rst;
      bat_pkg::S_APPLY: commit   = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  // Decide the outcome of the held item
  always_comb begin
    status_next = bat_pkg::ST_MISS;
    slot_next   = '0;
    count_next  = count;
    add_ok      = 1'b0;
    del_ok      = 1'b0;
    unique case (req_q)
      bat_pkg::REQ_ADD: begin
        if (any_hit) begin
          status_next = bat_pkg::ST_DUP;
        end else if (count >= COUNT_W'(TABLE_DEPTH)) begin
          status_next = bat_pkg::ST_FULL;
        end else begin
          status_next = bat_pkg::ST_OK;
          slot_next   = bat_pkg::SLOT_W'(count);
          count_next  = count + COUNT_W'(1);
          add_ok      = 1'b1;
        end
      end
      bat_pkg::REQ_DEL_AT: begin
        if (int'(slot_q) < int'(count)) begin
          status_next = bat_pkg::ST_OK;
          count_next  = count - COUNT_W'(1);
          del_ok      = 1'b1;
        end
      end
      bat_pkg::REQ_DEL_ADDR: begin
        if (any_hit) begin
          status_next = bat_pkg::ST_OK;
          count_next  = count - COUNT_W'(1);
          del_ok      = 1'b1;
        end
      end
      default: status_next = bat_pkg::ST_MISS;
    endcase
  end

  // Drive the cell control bundle
  always_comb begin
    ctrl.capture  = in_valid && in_ready;
    ctrl.add_en   = commit && add_ok;
    ctrl.shift_en = commit && del_ok;
    ctrl.by_index = (req_q == bat_pkg::REQ_DEL_AT);
  end

  // Advance state and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bat_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        count <= count_next;
      end
    end
  end

  // Hold the taken item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q  <= req_type;
      addr_q <= bp_address;
      slot_q <= slot_index;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status     <= status_next;
      added_slot <= slot_next;
      live_count <= bat_pkg::LIVE_W'(count_next);
    end
  end

endmodule

// ===== rtl/bat_cell.sv =====
// One slot of the breakpoint address table: holds an address, latches a match bit,
// and takes its right neighbor's address when a removal shifts the row. Uses bat_pkg.
module bat_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 5
) (
  input  logic                        clk,
  input  bat_pkg::cell_ctrl_t         ctrl,
  input  logic [COUNT_W-1:0]          count,
  input  logic [bat_pkg::SLOT_W-1:0]  pos,
  input  logic [bat_pkg::ADDR_W-1:0]  addr,
  input  logic [bat_pkg::ADDR_W-1:0]  next_entry,
  input  logic                        chain_in,
  output logic [bat_pkg::ADDR_W-1:0]  entry,
  output logic                        chain_out
);

  logic live;
  logic hit;
  logic take_next;
  logic write_here;

  // Slot holds a valid address only below the count
  assign live = (IDX < int'(count));

  // Prefix of matches: this slot lies at or after the first matching slot
  assign chain_out = chain_in | hit;

  // Decide whether this slot takes its neighbor's address on a removal
  always_comb begin
    if (ctrl.by_index) begin
      take_next = (IDX >= int'(pos));
    end else begin
      take_next = chain_out;
    end
  end

  assign write_here = ctrl.add_en && (count == COUNT_W'(IDX));

  // Latch the match bit when the item is taken
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit <= live && (entry == addr);
    end
  end

  // Append, shift down, or hold
  always_ff @(posedge clk) begin
    if (write_here) begin
      entry <= addr;
    end else if (ctrl.shift_en && take_next) begin
      entry <= next_entry;
    end
  end

endmodule
